/* sv/sot_pkg.sv */
// Shared definitions for the symbol occurrence table: default sizes,
// register map and the command/status bundles between controller and datapath.
// No dependencies.
package sot_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int SYMBOL_BITS_DEF   = 16;
    localparam int COUNT_BITS_DEF    = 32;

    // Register map: the index is byte address divided by four.
    localparam logic REG_SYMBOL_BYTES = 1'b0;

    // Commands from the controller to the datapath, at most one per cycle.
    typedef struct packed {
        logic load;         // latch the item and read entry 0
        logic scan_next;    // read the next stored symbol
        logic cnt_read;     // read the count of the matched entry
        logic hit_update;   // write back the raised count, post the result
        logic miss_update;  // append or drop the symbol, post the result
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic empty;        // no entries in use
        logic match;        // entry under compare matches the item
        logic last;         // entry under compare is the last one in use
    } t_dp_stat;

endpackage

/* sv/sot_ram.sv */
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module sot_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/sot_datapath.sv */
// Datapath of the symbol occurrence table: symbol and count memories,
// entry scan index, fill count, running total and the result registers.
// Depends on sot_pkg and sot_ram.
module sot_datapath #(
    parameter int TABLE_ENTRIES = sot_pkg::TABLE_ENTRIES_DEF,
    parameter int SYMBOL_BITS   = sot_pkg::SYMBOL_BITS_DEF,
    parameter int COUNT_BITS    = sot_pkg::COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sot_pkg::t_dp_cmd  i_cmd,
    input  logic [15:0]       i_symbol_value,
    input  logic [1:0]        i_symbol_bytes,
    output sot_pkg::t_dp_stat o_stat,
    output logic              o_done,
    output logic [31:0]       o_symbol_count,
    output logic [7:0]        o_entry_index,
    output logic              o_new_entry,
    output logic              o_table_full,
    output logic [8:0]        o_distinct_symbols,
    output logic [31:0]       o_total_symbols
);
    import sot_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int UW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [SYMBOL_BITS-1:0] r_sym;
    logic [SYMBOL_BITS-1:0] r_mask;
    logic [IW-1:0]          r_idx;
    logic [UW-1:0]          r_used;
    logic [COUNT_BITS-1:0]  r_total;
    logic                   r_done;
    logic [COUNT_BITS-1:0]  r_cnt_o;
    logic [IW-1:0]          r_idx_o;
    logic                   r_new;
    logic                   r_full;

    logic [SYMBOL_BITS-1:0] sym_rd_data;
    logic [COUNT_BITS-1:0]  cnt_rd_data;
    logic [UW-1:0]          idx_inc;
    logic                   room;
    logic                   insert;
    logic                   cnt_sat;
    logic [COUNT_BITS-1:0]  cnt_next;
    logic                   total_inc;
    logic [COUNT_BITS-1:0]  n_total;

    assign idx_inc   = UW'(r_idx) + UW'(1);
    assign room      = r_used < UW'(TABLE_ENTRIES);
    assign insert    = i_cmd.miss_update & room;
    assign cnt_sat   = cnt_rd_data == CNT_MAX;
    assign cnt_next  = cnt_sat ? cnt_rd_data : cnt_rd_data + COUNT_BITS'(1);
    assign total_inc = (i_cmd.hit_update & ~cnt_sat) | insert;
    assign n_total   = (total_inc && r_total != CNT_MAX) ? r_total + COUNT_BITS'(1) : r_total;

    assign o_stat.empty = r_used == '0;
    assign o_stat.match = ((sym_rd_data ^ r_sym) & r_mask) == '0;
    assign o_stat.last  = idx_inc == r_used;

    sot_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(TABLE_ENTRIES)) u_sym_ram (
        .i_clk     (i_clk),
        .i_wr_en   (insert),
        .i_wr_addr (r_used[IW-1:0]),
        .i_wr_data (r_sym),
        .i_rd_en   (i_cmd.load | i_cmd.scan_next),
        .i_rd_addr (i_cmd.load ? '0 : idx_inc[IW-1:0]),
        .o_rd_data (sym_rd_data)
    );

    sot_ram #(.WIDTH(COUNT_BITS), .DEPTH(TABLE_ENTRIES)) u_cnt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.hit_update | insert),
        .i_wr_addr (i_cmd.hit_update ? r_idx : r_used[IW-1:0]),
        .i_wr_data (i_cmd.hit_update ? cnt_next : COUNT_BITS'(1)),
        .i_rd_en   (i_cmd.cnt_read),
        .i_rd_addr (r_idx),
        .o_rd_data (cnt_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_total <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done  <= i_cmd.hit_update | i_cmd.miss_update;
            r_total <= n_total;
            if (insert) begin
                r_used <= r_used + UW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sym  <= SYMBOL_BITS'(i_symbol_value);
            r_mask <= SYMBOL_BITS'(i_symbol_bytes[1] ? 16'hFFFF : 16'h00FF);
            r_idx  <= '0;
        end else if (i_cmd.scan_next) begin
            r_idx <= idx_inc[IW-1:0];
        end
        if (i_cmd.hit_update) begin
            r_cnt_o <= cnt_next;
            r_idx_o <= r_idx;
            r_new   <= 1'b0;
            r_full  <= 1'b0;
        end else if (i_cmd.miss_update) begin
            r_cnt_o <= room ? COUNT_BITS'(1) : '0;
            r_idx_o <= room ? r_used[IW-1:0] : '0;
            r_new   <= room;
            r_full  <= ~room;
        end
    end

    assign o_done             = r_done;
    assign o_symbol_count     = 32'(r_cnt_o);
    assign o_entry_index      = 8'(r_idx_o);
    assign o_new_entry        = r_new;
    assign o_table_full       = r_full;
    assign o_distinct_symbols = 9'(r_used);
    assign o_total_symbols    = 32'(r_total);

endmodule

/* sv/sot_ctrl.sv */
// Controller of the symbol occurrence table: steps the scan over the stored
// symbols and sequences the count update. Depends on sot_pkg.
module sot_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  sot_pkg::t_dp_stat i_stat,
    output logic              busy,
    output sot_pkg::t_dp_cmd  o_cmd
);
    import sot_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_HIT  = 2'd2;
    localparam logic [1:0] S_MISS = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.empty ? S_MISS : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.match) begin
                    o_cmd.cnt_read = 1'b1;
                    n_state        = S_HIT;
                end else if (i_stat.last) begin
                    n_state = S_MISS;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_HIT: begin
                o_cmd.hit_update = 1'b1;
                n_state          = S_IDLE;
            end
            S_MISS: begin
                o_cmd.miss_update = 1'b1;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = r_state != S_IDLE;

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command in a cycle");

    a_scan_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_next |-> !i_stat.match && !i_stat.last)
        else $error("scan advanced past a match or past the last entry");

    a_hit_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cnt_read |=> o_cmd.hit_update)
        else $error("count read not followed by the count update");

    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> r_state == S_SCAN || r_state == S_MISS)
        else $error("accepted item did not enter the scan or the append step");

endmodule

/* sv/symbol_occurrence_table.sv */
// Top level of the symbol occurrence table: configuration register port
// and the controller/datapath pair. Depends on sot_pkg, sot_ctrl,
// sot_datapath (and through it sot_ram).
//
// Usage. An item carries one symbol on i_symbol_value and is accepted at a
// rising edge where start is high and busy is low. The symbol is compared,
// under the low one or two bytes selected by the symbol_bytes register,
// against the distinct symbols held so far in first-seen order. A match
// raises that entry's count; an unseen symbol is appended with a count of
// one, or dropped with o_table_full set when every entry is taken. Counts
// and the running total saturate.
// Each item yields one result, shown for exactly one cycle with o_done high.
// The receiver cannot stall, so a result that is not taken in that cycle is
// gone; busy already falls in the result cycle, and a new item may be
// accepted at the edge that ends it.
// Timing: the stored symbols sit in one memory that is scanned one entry per
// cycle through its single read port. A matching item is scanned up to its
// entry, whose count is then read and written back; an unseen symbol is
// scanned past every entry in use (none when the table is empty) and then
// appended or dropped. The result strobe marks the end of each item.
// Reset (synchronous, active low) empties the table, clears the total and
// sets symbol_bytes to two. The memories need no clearing pass: only entries
// below the fill count are ever used. Write symbol_bytes only while idle.
module symbol_occurrence_table #(
    parameter int TABLE_ENTRIES = sot_pkg::TABLE_ENTRIES_DEF,
    parameter int SYMBOL_BITS   = sot_pkg::SYMBOL_BITS_DEF,
    parameter int COUNT_BITS    = sot_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Item channel.
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_symbol_value,
    // Result channel.
    output logic        o_done,
    output logic [31:0] o_symbol_count,
    output logic [7:0]  o_entry_index,
    output logic        o_new_entry,
    output logic        o_table_full,
    output logic [8:0]  o_distinct_symbols,
    output logic [31:0] o_total_symbols
);
    import sot_pkg::*;

    logic [1:0] r_symbol_bytes;
    logic       cfg_wr;
    t_dp_cmd    dp_cmd;
    t_dp_stat   dp_stat;

    // The access phase completes at once; only register 0 exists, so the
    // index bit of the byte address selects it.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_SYMBOL_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_bytes <= 2'd2;
        end else if (cfg_wr) begin
            r_symbol_bytes <= pwdata[1:0];
        end
    end

    assign prdata = (paddr[2] == REG_SYMBOL_BYTES) ? {30'd0, r_symbol_bytes} : 32'd0;

    // The controller walks the stored symbols and orders the update; the
    // datapath holds the memories, the fill count and the total.
    sot_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (dp_stat),
        .busy    (busy),
        .o_cmd   (dp_cmd)
    );

    sot_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SYMBOL_BITS   (SYMBOL_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .i_symbol_value     (i_symbol_value),
        .i_symbol_bytes     (r_symbol_bytes),
        .o_stat             (dp_stat),
        .o_done             (o_done),
        .o_symbol_count     (o_symbol_count),
        .o_entry_index      (o_entry_index),
        .o_new_entry        (o_new_entry),
        .o_table_full       (o_table_full),
        .o_distinct_symbols (o_distinct_symbols),
        .o_total_symbols    (o_total_symbols)
    );

endmodule
